// ----- hdl/ldmc_pkg.sv -----
// Package for the LDMIA-to-LDR cracker: encoding constants, sequencer states,
// the per-cycle emit record and the LDR encoder. No dependencies.
package ldmc_pkg;

    localparam int unsigned WordWidth = 32;
    localparam int unsigned RegCount  = 16;
    localparam int unsigned IdxWidth  = 4;
    localparam int unsigned OffWidth  = 6;

    localparam logic [WordWidth-1:0] QUAL_MASK    = 32'hFFF0_0000;
    localparam logic [WordWidth-1:0] QUAL_VALUE   = 32'hE890_0000;
    localparam logic [IdxWidth-1:0]  BASE_LIMIT   = 4'd13;
    localparam logic [IdxWidth-1:0]  REG_PC       = 4'd15;
    localparam logic [WordWidth-1:0] LDR_PC_BACK  = 32'hE51F_F004;
    localparam logic [WordWidth-1:0] LDR_IMM_BASE = 32'hE590_0000;
    localparam logic [WordWidth-1:0] WORD_STEP    = 32'd4;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_LIT
    } t_state;

    // One result word produced by the sequencer in a cycle.
    typedef struct packed {
        logic                 valid;
        logic [WordWidth-1:0] word;
        logic                 last;
    } t_emit;

    // Encode LDR rt,[rn,#off] with a positive immediate offset.
    function automatic logic [WordWidth-1:0] make_ldr(
        input logic [IdxWidth-1:0] rt,
        input logic [IdxWidth-1:0] rn,
        input logic [OffWidth-1:0] off
    );
        make_ldr = LDR_IMM_BASE | {12'd0, rn, rt, 6'd0, off};
    endfunction

endpackage

// ----- hdl/ldmc_if.sv -----
// Handshake channels of the cracker: one for instruction items in, one for
// result words out. Depends on ldmc_pkg for the word width.
interface ldmc_in_if import ldmc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WordWidth-1:0] instr_word;
    logic [WordWidth-1:0] instr_address;

    modport source (output valid, output instr_word, output instr_address, input ready);
    modport sink (input valid, input instr_word, input instr_address, output ready);
endinterface

interface ldmc_out_if import ldmc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WordWidth-1:0] out_word;
    logic                 is_last;

    modport source (output valid, output out_word, output is_last, input ready);
    modport sink (input valid, input out_word, input is_last, output ready);
endinterface

// ----- hdl/ldmc_seq.sv -----
// Sequencer of the cracker: qualifies an instruction, scans its register list
// one slot per cycle while i_adv is high and produces the replacement words. Uses ldmc_pkg.
module ldmc_seq import ldmc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WordWidth-1:0] i_word,
    input  logic [WordWidth-1:0] i_addr,
    input  logic                 i_adv,
    output logic                 o_idle,
    output t_emit                o_emit
);

    t_state                r_state, n_state;
    logic [RegCount-1:0]   r_list,  n_list;
    logic [IdxWidth-1:0]   r_base,  n_base;
    logic [WordWidth-1:0]  r_addr,  n_addr;
    logic [IdxWidth-1:0]   r_idx,   n_idx;
    logic [OffWidth-1:0]   r_off,   n_off;
    logic [OffWidth-1:0]   r_hoff,  n_hoff;
    logic                  r_held,  n_held;

    logic [WordWidth-1:0]  add_a;
    logic [WordWidth-1:0]  add_sum;
    logic                  qualifies;
    logic                  slot_bit;

    // Shared adder: steps the load offset while scanning and forms the
    // return literal at the end.
    assign add_a   = (r_state == ST_LIT) ? r_addr : {{(WordWidth-OffWidth){1'b0}}, r_off};
    assign add_sum = add_a + WORD_STEP;

    assign qualifies = ((i_word & QUAL_MASK) == QUAL_VALUE) && (i_word[19:16] < BASE_LIMIT);
    assign slot_bit  = r_list[r_idx];
    assign o_idle    = (r_state == ST_IDLE);

    // Next state and emitted word.
    always_comb begin
        n_state = r_state;
        n_list  = r_list;
        n_base  = r_base;
        n_addr  = r_addr;
        n_idx   = r_idx;
        n_off   = r_off;
        n_hoff  = r_hoff;
        n_held  = r_held;
        o_emit  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start && qualifies) begin
                    n_list  = i_word[RegCount-1:0];
                    n_base  = i_word[19:16];
                    n_addr  = i_addr;
                    n_idx   = '0;
                    n_off   = '0;
                    n_held  = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_adv) begin
                    if (slot_bit && r_held && (r_idx == REG_PC)) begin
                        // The deferred base load goes just ahead of the PC load.
                        o_emit.valid = 1'b1;
                        o_emit.word  = make_ldr(r_base, r_base, r_hoff);
                        n_held       = 1'b0;
                    end else begin
                        if (slot_bit) begin
                            n_off = add_sum[OffWidth-1:0];
                            if (r_idx == r_base) begin
                                n_held = 1'b1;
                                n_hoff = r_off;
                            end else begin
                                o_emit.valid = 1'b1;
                                o_emit.word  = make_ldr(r_idx, r_base, r_off);
                            end
                        end
                        if (r_idx == REG_PC) begin
                            n_state = ST_TAIL;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                end
            end
            ST_TAIL: begin
                if (i_adv) begin
                    o_emit.valid = 1'b1;
                    if (r_held) begin
                        o_emit.word = make_ldr(r_base, r_base, r_hoff);
                        n_held      = 1'b0;
                    end else begin
                        o_emit.word = LDR_PC_BACK;
                        n_state     = ST_LIT;
                    end
                end
            end
            ST_LIT: begin
                if (i_adv) begin
                    o_emit.valid = 1'b1;
                    o_emit.word  = add_sum;
                    o_emit.last  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
        end
    end

    // Working registers of the current instruction.
    always_ff @(posedge i_clk) begin
        r_list <= n_list;
        r_base <= n_base;
        r_addr <= n_addr;
        r_idx  <= n_idx;
        r_off  <= n_off;
        r_hoff <= n_hoff;
    end

endmodule

// ----- hdl/ldm_to_ldr_cracker_unit.sv -----
// Top level of the LDMIA-to-LDR cracker: input channel, sequencer and the
// output register. Uses ldmc_pkg, ldmc_in_if, ldmc_out_if and ldmc_seq.
//
// An instruction transfer is taken only while the block is idle. A word that
// is not an unconditional LDMIA without writeback with a base below r13 is
// dropped in its own transfer cycle and produces nothing. A qualifying word
// keeps the input not ready until its last word has been produced. The
// sequencer visits all sixteen register-list slots, whether set or not, one
// per cycle while the output is not stalled, then emits LDR PC,[PC,#-4] and
// the return literal. A base in the list gets a deferred load, which goes out
// either just ahead of the PC load or after the scan. Results leave through a
// single output register, and the final literal is flagged by is_last.
module ldm_to_ldr_cracker_unit import ldmc_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    ldmc_in_if.sink   i_in,
    ldmc_out_if.source o_out
);

    logic                 seq_idle;
    logic                 in_xfer;
    logic                 slot_free;
    t_emit                seq_emit;

    logic                 r_out_valid;
    logic [WordWidth-1:0] r_out_word;
    logic                 r_out_last;

    assign i_in.ready = seq_idle;
    assign in_xfer    = i_in.valid && seq_idle;
    assign slot_free  = !r_out_valid || o_out.ready;

    ldmc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_word  (i_in.instr_word),
        .i_addr  (i_in.instr_address),
        .i_adv   (slot_free),
        .o_idle  (seq_idle),
        .o_emit  (seq_emit)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload, loaded whenever the sequencer produces a word.
    always_ff @(posedge i_clk) begin
        if (seq_emit.valid) begin
            r_out_word <= seq_emit.word;
            r_out_last <= seq_emit.last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_word = r_out_word;
    assign o_out.is_last  = r_out_last;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for ldm_to_ldr_cracker_unit: directed and random LDMIA words,
// with each expanded LDR sequence predicted and compared word by word.
// Depends on ldmc_pkg, ldmc_in_if, ldmc_out_if and the cracker RTL.
`timescale 1ns / 100ps

typedef struct packed {
    logic [31:0] word;
    logic        last;
} crack_word_t;

// Predicts the LDR expansion of every accepted instruction and checks the output words.
class crack_scoreboard;
    crack_word_t expected_words[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    // Expand one accepted instruction into the words the block must emit.
    function void note_instruction(logic [31:0] instr, logic [31:0] addr);
        logic [3:0]  base_reg;
        logic [15:0] reg_list;
        logic [31:0] offset;
        logic [31:0] deferred_ldr;
        bit          deferred_pending;
        base_reg         = instr[19:16];
        reg_list         = instr[15:0];
        offset           = 32'd0;
        deferred_ldr     = 32'd0;
        deferred_pending = 1'b0;
        if ((instr & ldmc_pkg::QUAL_MASK) != ldmc_pkg::QUAL_VALUE
                || base_reg >= ldmc_pkg::BASE_LIMIT) begin
            return;
        end
        for (int r = 0; r < 16; r++) begin
            if (reg_list[r]) begin
                if (r == base_reg) begin
                    // The base load is held back so the other loads still see the base.
                    deferred_ldr = ldmc_pkg::LDR_IMM_BASE | {12'd0, base_reg, 4'(r), offset[11:0]};
                    deferred_pending = 1'b1;
                end else begin
                    // A held base load must still run before control leaves through PC.
                    if (r == ldmc_pkg::REG_PC && deferred_pending) begin
                        expected_words.push_back('{deferred_ldr, 1'b0});
                        deferred_pending = 1'b0;
                    end
                    expected_words.push_back('{ldmc_pkg::LDR_IMM_BASE
                        | {12'd0, base_reg, 4'(r), offset[11:0]}, 1'b0});
                end
                offset = offset + 32'd4;
            end
        end
        if (deferred_pending) begin
            expected_words.push_back('{deferred_ldr, 1'b0});
        end
        expected_words.push_back('{ldmc_pkg::LDR_PC_BACK, 1'b0});
        expected_words.push_back('{addr + 32'd4, 1'b1});
    endfunction

    // Compare one output transfer with the oldest expected word.
    function void check_word(logic [31:0] word, logic last);
        crack_word_t want;
        if (expected_words.size() == 0) begin
            errors++;
            if (errors <= 30) begin
                $display("%0t: unexpected word: expected none, actual %h last %b",
                         $time, word, last);
            end
            return;
        end
        want = expected_words.pop_front();
        if (want.word !== word) begin
            errors++;
            if (errors <= 30) begin
                $display("%0t: out_word mismatch: expected %h, actual %h",
                         $time, want.word, word);
            end
        end
        if (want.last !== last) begin
            errors++;
            if (errors <= 30) begin
                $display("%0t: is_last mismatch on %h: expected %b, actual %b",
                         $time, want.word, want.last, last);
            end
        end
    endfunction

    function int pending();
        return expected_words.size();
    endfunction
endclass

module testbench;
    import ldmc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 40;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   pressure_armed;
    bit   pressure_done;
    int   hold_left;
    int   cycle_count;

    crack_scoreboard word_check;

    ldmc_in_if  in_ch();
    ldmc_out_if out_ch();

    ldm_to_ldr_cracker_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result receiver: random stalls, plus one long hold-off once pressure is armed.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (pressure_armed && !pressure_done) begin
            hold_left = LONG_HOLD;
            pressure_done = 1'b1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every output transfer is checked against the prediction.
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            word_check.check_word(out_ch.out_word, out_ch.is_last);
        end
    end

    // Offer one instruction, with random idle cycles before it, until it is taken.
    task automatic send_instr(input logic [31:0] instr, input logic [31:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.instr_word    <= instr;
        in_ch.instr_address <= addr;
        do @(posedge clk); while (!in_ch.ready);
        word_check.note_instruction(instr, addr);
    endtask

    // Mostly well-formed LDMIA words with random lists, mixed with words that must be dropped.
    task automatic run_random(input int count);
        int          taken;
        logic [31:0] rnd;
        logic [31:0] instr;
        logic [31:0] addr;
        logic [3:0]  base_reg;
        logic [15:0] reg_list;
        bit          well_formed;
        taken = 0;
        while (taken < count) begin
            rnd      = $urandom;
            base_reg = 4'($urandom_range(12));
            case ($urandom_range(9))
                0: reg_list = 16'h0000;
                1: reg_list = 16'hFFFF;
                2: reg_list = 16'h0001 << $urandom_range(15);
                3: reg_list = (16'h0001 << base_reg) | 16'h8000 | (rnd[15:0] & rnd[31:16]);
                default: reg_list = rnd[15:0];
            endcase
            well_formed = ($urandom_range(99) < 75);
            instr = {12'hE89, base_reg, reg_list};
            if (!well_formed) begin
                rnd = $urandom;
                case ($urandom_range(3))
                    0: instr = rnd;
                    1: instr = {12'hE89, 4'(13 + $urandom_range(2)), rnd[15:0]};
                    2: instr = instr ^ (32'h1 << (20 + $urandom_range(11)));
                    default: instr = {4'hE, rnd[27:0]};
                endcase
            end
            rnd = $urandom;
            case ($urandom_range(9))
                0: addr = rnd;
                1: addr = 32'hFFFF_FFFC - 32'(4 * $urandom_range(2));
                default: addr = {rnd[31:2], 2'b00};
            endcase
            send_instr(instr, addr);
            taken++;
        end
    endtask

    initial begin
        word_check           = new();
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.instr_word     = '0;
        in_ch.instr_address  = '0;
        out_ch.ready         = 1'b0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        pressure_armed       = 1'b0;
        pressure_done        = 1'b0;
        hold_left            = 0;
        cycle_count          = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty list, full lists, base and PC handling, address wrap.
        send_instr(32'hE890_0000, 32'h0000_0000);
        send_instr(32'hE89C_FFFF, 32'hFFFF_FFFC);
        send_instr(32'hE890_FFFF, 32'h0000_1000);
        send_instr(32'hE895_0020, 32'h8000_0004);
        send_instr(32'hE893_8008, 32'h0001_2340);
        send_instr(32'hE891_8000, 32'hFFFF_FFFF);
        send_instr(32'hE892_7FFB, 32'h5555_5554);
        send_instr(32'hE89A_0401, 32'hAAAA_AAAA);
        send_instr(32'hE894_5555, 32'h7FFF_FFFC);
        send_instr(32'hE897_AAAA, 32'h0000_0003);
        send_instr(32'hE89C_1000, 32'h1234_5678);
        // Directed: words that must be dropped.
        send_instr(32'hE89D_00FF, 32'h0000_0010);
        send_instr(32'hE89E_FFFF, 32'h0000_0014);
        send_instr(32'hE89F_8001, 32'h0000_0018);
        send_instr(32'hE8B0_00FF, 32'h0000_001C);
        send_instr(32'h0890_00FF, 32'h0000_0020);
        send_instr(32'hE810_00FF, 32'h0000_0024);
        send_instr(32'hE990_00FF, 32'h0000_0028);
        send_instr(32'hF890_00FF, 32'h0000_002C);
        send_instr(32'hE8D0_00FF, 32'h0000_0030);
        send_instr(32'h0000_0000, 32'hFFFF_FFFF);
        send_instr(32'hFFFF_FFFF, 32'h0000_0000);

        // Random phases with different idle patterns on both sides.
        run_random(90);
        send_idle_pct  = 73;
        recv_stall_pct = 0;
        run_random(90);
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        run_random(90);
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        run_random(90);

        // Long receiver hold-off while the sender keeps offering.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_armed = 1'b1;
        run_random(40);

        in_ch.valid <= 1'b0;
        while (word_check.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (word_check.pending() != 0) begin
            word_check.errors++;
            $display("%0t: %0d expected words never arrived", $time, word_check.pending());
        end
        if (word_check.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
